// ----- sv/wspm_pkg.sv -----
// Shared types and constants for the wheel speed period meter.
// No dependencies; imported by every module of the block.
package wspm_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 32;

    localparam int CIRC_BITS      = 12;
    localparam int MIN_PER_BITS   = 10;
    localparam int SPEED_BITS     = 16;
    localparam int STAMP_BITS     = 32;
    localparam int OUT_BITS       = 32;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_IDX_BITS   = 2;

    localparam int K_BITS         = 10;
    localparam logic [K_BITS-1:0] MS_PER_S = 10'd1000;
    localparam int NUM_BITS       = CIRC_BITS + K_BITS;
    localparam int STEP_BITS      = $clog2(NUM_BITS);

    localparam logic [SPEED_BITS-1:0]   SPEED_MAX    = 16'hFFFF;
    localparam logic [CIRC_BITS-1:0]    CIRC_RST     = 12'd2000;
    localparam logic [MIN_PER_BITS-1:0] MIN_PER_RST  = 10'd72;
    localparam logic [SPEED_BITS-1:0]   MIN_SPD_RST  = 16'd278;

    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CIRC       = 2'd0,
        CFG_MIN_PERIOD = 2'd1,
        CFG_MIN_SPEED  = 2'd2,
        CFG_TRIP_EN    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic capture;
        logic div_init;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic div_skip;
    } sts_t;

endpackage

// ----- sv/wspm_ctrl.sv -----
// Controller FSM: request sequencing, divider step count, output valid.
// Depends on wspm_pkg.
module wspm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  wspm_pkg::sts_t  sts,
    output wspm_pkg::cmd_t  cmd
);
    import wspm_pkg::*;

    state_t                 state_reg, state_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = sts.div_skip ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(NUM_BITS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // commit never overwrites an untaken result
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit while output occupied");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result not presented after commit");

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_LOAD))
        else $error("accepted request not loaded");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (step_reg < STEP_BITS'(NUM_BITS)))
        else $error("divider step count out of range");

endmodule

// ----- sv/wspm_dp.sv -----
// Datapath: config registers, meter state, restoring divider, result registers.
// Depends on wspm_pkg; driven by wspm_ctrl commands.
module wspm_dp #(
    parameter int TIME_BITS  = wspm_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = wspm_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wspm_pkg::cmd_t                        cmd,
    output wspm_pkg::sts_t                        sts,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wspm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [wspm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  op,
    input  logic [wspm_pkg::STAMP_BITS-1:0]       now_ms,
    input  logic                                  clear_moving_time,
    input  logic                                  clear_total_revs,
    input  logic                                  clear_trip_revs,
    output logic [wspm_pkg::SPEED_BITS-1:0]       speed_mmps,
    output logic [wspm_pkg::OUT_BITS-1:0]         trip_revs,
    output logic [wspm_pkg::OUT_BITS-1:0]         total_revs,
    output logic [wspm_pkg::OUT_BITS-1:0]         moving_time_ms,
    output logic                                  pulse_accepted
);
    import wspm_pkg::*;

    logic [CIRC_BITS-1:0]    circ_reg;
    logic [MIN_PER_BITS-1:0] min_per_reg;
    logic [SPEED_BITS-1:0]   min_spd_reg;
    logic                    trip_en_reg;

    logic [TIME_BITS-1:0]    last_pulse_reg, last_pulse_next;
    logic [SPEED_BITS-1:0]   last_speed_reg, last_speed_next;
    logic                    fresh_reg, fresh_next;
    logic [COUNT_BITS-1:0]   trip_reg, trip_next;
    logic [COUNT_BITS-1:0]   total_reg, total_next;
    logic [TIME_BITS-1:0]    moving_reg, moving_next;

    logic                    op_reg;
    logic [TIME_BITS-1:0]    now_reg;
    logic                    clr_mov_reg, clr_tot_reg, clr_trip_reg;

    logic [TIME_BITS-1:0]    delta_reg, delta_calc;
    logic [63:0]             delta_wide;
    logic                    div_zero_reg, div_big_reg;
    logic                    div_zero_calc, div_big_calc;
    logic [NUM_BITS-1:0]     dvsr_reg;
    logic [NUM_BITS-1:0]     quo_reg;
    logic [NUM_BITS-1:0]     rem_reg;
    logic [NUM_BITS:0]       rem_shift, rem_diff;
    logic [NUM_BITS-1:0]     num_calc;

    logic [SPEED_BITS-1:0]   q_speed, read_low, read_speed;
    logic                    is_pulse, pulse_ok;

    logic [SPEED_BITS-1:0]   speed_out_reg;
    logic [OUT_BITS-1:0]     trip_out_reg, total_out_reg, moving_out_reg;
    logic                    acc_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg    <= CIRC_RST;
            min_per_reg <= MIN_PER_RST;
            min_spd_reg <= MIN_SPD_RST;
            trip_en_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CIRC:       circ_reg    <= cfg_data[CIRC_BITS-1:0];
                CFG_MIN_PERIOD: min_per_reg <= cfg_data[MIN_PER_BITS-1:0];
                CFG_MIN_SPEED:  min_spd_reg <= cfg_data[SPEED_BITS-1:0];
                CFG_TRIP_EN:    trip_en_reg <= cfg_data[0];
                default:        trip_en_reg <= trip_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= op;
            now_reg      <= TIME_BITS'(now_ms);
            clr_mov_reg  <= clear_moving_time;
            clr_tot_reg  <= clear_total_revs;
            clr_trip_reg <= clear_trip_revs;
        end
    end

    // period and numerator, then one quotient bit per cycle
    assign delta_calc    = now_reg - last_pulse_reg;
    assign delta_wide    = 64'(delta_calc);
    assign div_zero_calc = (delta_calc == '0);
    assign div_big_calc  = |delta_wide[63:NUM_BITS];
    assign num_calc      = NUM_BITS'(circ_reg) * NUM_BITS'(MS_PER_S);
    assign sts.div_skip  = div_zero_calc || div_big_calc;

    assign rem_shift = {rem_reg, quo_reg[NUM_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, dvsr_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            delta_reg    <= delta_calc;
            div_zero_reg <= div_zero_calc;
            div_big_reg  <= div_big_calc;
            dvsr_reg     <= delta_wide[NUM_BITS-1:0];
            quo_reg      <= num_calc;
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_diff[NUM_BITS])
            begin
                rem_reg <= rem_diff[NUM_BITS-1:0];
                quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[NUM_BITS-1:0];
                quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (div_zero_reg)
        begin
            q_speed = SPEED_MAX;
        end
        else if (div_big_reg)
        begin
            q_speed = '0;
        end
        else if (|quo_reg[NUM_BITS-1:SPEED_BITS])
        begin
            q_speed = SPEED_MAX;
        end
        else
        begin
            q_speed = quo_reg[SPEED_BITS-1:0];
        end
    end

    assign is_pulse   = (op_reg == OP_PULSE);
    assign pulse_ok   = is_pulse && (delta_reg >= TIME_BITS'(min_per_reg));
    assign read_low   = (fresh_reg || (last_speed_reg <= q_speed)) ? last_speed_reg : q_speed;
    assign read_speed = (read_low < min_spd_reg) ? '0 : read_low;

    always_comb
    begin
        last_pulse_next = last_pulse_reg;
        last_speed_next = last_speed_reg;
        fresh_next      = fresh_reg;
        trip_next       = trip_reg;
        total_next      = total_reg;
        moving_next     = moving_reg;
        if (cmd.commit)
        begin
            if (is_pulse)
            begin
                if (pulse_ok)
                begin
                    total_next      = total_reg + COUNT_BITS'(1);
                    trip_next       = trip_en_reg ? trip_reg + COUNT_BITS'(1) : trip_reg;
                    last_speed_next = q_speed;
                    moving_next     = (q_speed >= min_spd_reg) ? moving_reg + delta_reg
                                                               : moving_reg;
                    last_pulse_next = now_reg;
                    fresh_next      = 1'b1;
                end
            end
            else
            begin
                fresh_next  = 1'b0;
                moving_next = clr_mov_reg  ? '0 : moving_reg;
                total_next  = clr_tot_reg  ? '0 : total_reg;
                trip_next   = clr_trip_reg ? '0 : trip_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pulse_reg <= '0;
            last_speed_reg <= '0;
            fresh_reg      <= 1'b0;
            trip_reg       <= '0;
            total_reg      <= '0;
            moving_reg     <= '0;
        end
        else
        begin
            last_pulse_reg <= last_pulse_next;
            last_speed_reg <= last_speed_next;
            fresh_reg      <= fresh_next;
            trip_reg       <= trip_next;
            total_reg      <= total_next;
            moving_reg     <= moving_next;
        end
    end

    // pulses report counts after update, reads before clear
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (is_pulse)
            begin
                speed_out_reg  <= pulse_ok ? q_speed : last_speed_reg;
                trip_out_reg   <= OUT_BITS'(trip_next);
                total_out_reg  <= OUT_BITS'(total_next);
                moving_out_reg <= OUT_BITS'(moving_next);
            end
            else
            begin
                speed_out_reg  <= read_speed;
                trip_out_reg   <= OUT_BITS'(trip_reg);
                total_out_reg  <= OUT_BITS'(total_reg);
                moving_out_reg <= OUT_BITS'(moving_reg);
            end
            acc_out_reg <= pulse_ok;
        end
    end

    assign speed_mmps     = speed_out_reg;
    assign trip_revs      = trip_out_reg;
    assign total_revs     = total_out_reg;
    assign moving_time_ms = moving_out_reg;
    assign pulse_accepted = acc_out_reg;

    a_read_clears_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !is_pulse) |=> !fresh_reg)
        else $error("read left fresh flag set");

    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && is_pulse && !pulse_ok) |=> $stable(total_reg) && $stable(last_pulse_reg))
        else $error("rejected pulse changed state");

    a_accept_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && pulse_ok) |=> (total_reg == $past(total_reg) + COUNT_BITS'(1)))
        else $error("accepted pulse not counted");

endmodule

// ----- sv/wheel_speed_period_meter_core.sv -----
// Wheel speed period meter, top level: wspm_ctrl sequences wspm_dp.
// Flow: S_IDLE captures the request, S_LOAD loads the divider, S_DIV runs the 22-step
// restoring divider (skipped when the period is 0 or at least 2^22 ms), S_DONE commits.
// S_DONE waits for a free output register; requests are taken only in S_IDLE, so the next
// request is taken while a result waits in the output register.
// Reset: asynchronous active-low; clears counters, state and output valid,
// config registers return to their defaults.
module wheel_speed_period_meter_core #(
    parameter int TIME_BITS  = wspm_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = wspm_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wspm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [wspm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  op,
    input  logic [wspm_pkg::STAMP_BITS-1:0]       now_ms,
    input  logic                                  clear_moving_time,
    input  logic                                  clear_total_revs,
    input  logic                                  clear_trip_revs,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [wspm_pkg::SPEED_BITS-1:0]       speed_mmps,
    output logic [wspm_pkg::OUT_BITS-1:0]         trip_revs,
    output logic [wspm_pkg::OUT_BITS-1:0]         total_revs,
    output logic [wspm_pkg::OUT_BITS-1:0]         moving_time_ms,
    output logic                                  pulse_accepted
);
    import wspm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    wspm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    wspm_dp #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .op                (op),
        .now_ms            (now_ms),
        .clear_moving_time (clear_moving_time),
        .clear_total_revs  (clear_total_revs),
        .clear_trip_revs   (clear_trip_revs),
        .speed_mmps        (speed_mmps),
        .trip_revs         (trip_revs),
        .total_revs        (total_revs),
        .moving_time_ms    (moving_time_ms),
        .pulse_accepted    (pulse_accepted)
    );

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for wheel_speed_period_meter_core: directed and random pulse/read
// requests, with predicted readings compared field by field against every result.
// Depends on wspm_pkg and the core RTL only.
module testbench;
    import wspm_pkg::*;

    typedef struct packed {
        logic [15:0] speed;
        logic [31:0] trip;
        logic [31:0] total;
        logic [31:0] moving;
        logic        accepted;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [31:0] now_ms;
    logic        clear_moving_time;
    logic        clear_total_revs;
    logic        clear_trip_revs;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] speed_mmps;
    logic [31:0] trip_revs;
    logic [31:0] total_revs;
    logic [31:0] moving_time_ms;
    logic        pulse_accepted;

    // predicted meter state and registers
    logic [11:0] m_circ       = CIRC_RST;
    logic [9:0]  m_min_period = MIN_PER_RST;
    logic [15:0] m_min_speed  = MIN_SPD_RST;
    logic        m_trip_en    = 1'b0;
    logic [31:0] m_last_ms    = '0;
    logic [15:0] m_last_speed = '0;
    logic        m_fresh      = 1'b0;
    logic [31:0] m_trip       = '0;
    logic [31:0] m_total      = '0;
    logic [31:0] m_moving     = '0;

    reading_t expected_readings[$];
    int       mismatch_count = 0;
    bit       sender_idle    = 1'b0;
    bit       receiver_idle  = 1'b0;

    wheel_speed_period_meter_core u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .op                (op),
        .now_ms            (now_ms),
        .clear_moving_time (clear_moving_time),
        .clear_total_revs  (clear_total_revs),
        .clear_trip_revs   (clear_trip_revs),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .speed_mmps        (speed_mmps),
        .trip_revs         (trip_revs),
        .total_revs        (total_revs),
        .moving_time_ms    (moving_time_ms),
        .pulse_accepted    (pulse_accepted)
    );

    always #1 clk = ~clk;

    function automatic logic [15:0] speed_of_period(input logic [31:0] period);
        logic [31:0] num;
        logic [31:0] q;
        if (period == 32'd0)
            return SPEED_MAX;
        num = 32'(m_circ) * 32'd1000;
        q = num / period;
        return (q > 32'd65535) ? SPEED_MAX : q[15:0];
    endfunction

    function automatic reading_t meter_predict(input logic op_i, input logic [31:0] now_i,
                                               input logic clr_mov, input logic clr_tot,
                                               input logic clr_trip);
        reading_t    r;
        logic [31:0] delta;
        logic [15:0] spd;
        logic [15:0] decayed;
        delta = now_i - m_last_ms;
        r.accepted = 1'b0;
        if (op_i == OP_PULSE) begin
            if (delta < 32'(m_min_period)) begin
                spd = m_last_speed;
            end
            else begin
                r.accepted = 1'b1;
                m_total = m_total + 32'd1;
                if (m_trip_en)
                    m_trip = m_trip + 32'd1;
                spd = speed_of_period(delta);
                m_last_speed = spd;
                if (spd >= m_min_speed)
                    m_moving = m_moving + delta;
                m_last_ms = now_i;
                m_fresh = 1'b1;
            end
            r.speed  = spd;
            r.trip   = m_trip;
            r.total  = m_total;
            r.moving = m_moving;
        end
        else begin
            spd = m_last_speed;
            if (!m_fresh) begin
                decayed = speed_of_period(delta);
                if (decayed < spd)
                    spd = decayed;
            end
            m_fresh = 1'b0;
            if (spd < m_min_speed)
                spd = '0;
            r.speed  = spd;
            r.trip   = m_trip;
            r.total  = m_total;
            r.moving = m_moving;
            if (clr_mov)
                m_moving = '0;
            if (clr_tot)
                m_total = '0;
            if (clr_trip)
                m_trip = '0;
        end
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        reading_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_readings.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual speed %0d",
                         $time, speed_mmps);
            end
            else begin
                want = expected_readings.pop_front();
                report_field("speed_mmps", 32'(want.speed), 32'(speed_mmps));
                report_field("trip_revs", want.trip, trip_revs);
                report_field("total_revs", want.total, total_revs);
                report_field("moving_time_ms", want.moving, moving_time_ms);
                report_field("pulse_accepted", 32'(want.accepted), 32'(pulse_accepted));
            end
        end
    end

    // result side back-pressure
    initial begin
        int n;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            n = receiver_idle ? $urandom_range(0, 13) : 0;
            if (n > 0) begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic send_request(input logic op_i, input logic [31:0] now_i,
                                input logic clr_mov, input logic clr_tot,
                                input logic clr_trip);
        int gap;
        gap = sender_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        op                <= op_i;
        now_ms            <= now_i;
        clear_moving_time <= clr_mov;
        clear_total_revs  <= clr_tot;
        clear_trip_revs   <= clr_trip;
        do
            @(posedge clk);
        while (!in_ready);
        expected_readings.push_back(meter_predict(op_i, now_i, clr_mov, clr_tot, clr_trip));
    endtask

    task automatic hold_until_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle;
        hold_until_drained();
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CIRC:       m_circ       = data[11:0];
            CFG_MIN_PERIOD: m_min_period = data[9:0];
            CFG_MIN_SPEED:  m_min_speed  = data;
            CFG_TRIP_EN:    m_trip_en    = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] circ_d, input logic [15:0] minp_d,
                             input logic [15:0] mins_d, input logic [15:0] trip_d);
        wait_idle();
        write_reg(CFG_CIRC, circ_d);
        write_reg(CFG_MIN_PERIOD, minp_d);
        write_reg(CFG_MIN_SPEED, mins_d);
        write_reg(CFG_TRIP_EN, trip_d);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_defaults;
        send_request(OP_READ, 32'd0, 1'b0, 1'b0, 1'b0);
        send_request(OP_PULSE, 32'd71, 1'b0, 1'b0, 1'b0);
        send_request(OP_PULSE, 32'd72, 1'b0, 1'b0, 1'b0);
        send_request(OP_READ, 32'd72, 1'b0, 1'b0, 1'b0);
        send_request(OP_READ, 32'd5000, 1'b0, 1'b0, 1'b0);
        send_request(OP_PULSE, 32'd200072, 1'b0, 1'b0, 1'b0);
        send_request(OP_PULSE, 32'd200372, 1'b0, 1'b0, 1'b0);
        send_request(OP_PULSE, 32'd201372, 1'b1, 1'b1, 1'b1);
        send_request(OP_READ, 32'd201382, 1'b1, 1'b1, 1'b1);
        send_request(OP_READ, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_request(OP_PULSE, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0);
        send_request(OP_PULSE, 32'h0000_0040, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_directed_extremes;
        // max circumference, zero min period, max min speed, trip on
        configure(16'hFFFF, 16'hFC00, 16'hFFFF, 16'h0001);
        send_request(OP_PULSE, m_last_ms, 1'b0, 1'b0, 1'b0);
        send_request(OP_PULSE, m_last_ms, 1'b0, 1'b0, 1'b0);
        send_request(OP_PULSE, m_last_ms + 32'd1, 1'b0, 1'b0, 1'b0);
        send_request(OP_READ, m_last_ms, 1'b0, 1'b0, 1'b0);
        send_request(OP_READ, m_last_ms + 32'd1, 1'b0, 1'b0, 1'b0);
        send_request(OP_READ, m_last_ms + 32'd100, 1'b0, 1'b0, 1'b1);
        // zero circumference, max min period, zero min speed, trip off
        configure(16'hF000, 16'h03FF, 16'h0000, 16'hFFFE);
        send_request(OP_PULSE, m_last_ms + 32'd1022, 1'b0, 1'b0, 1'b0);
        send_request(OP_PULSE, m_last_ms + 32'd1023, 1'b0, 1'b0, 1'b0);
        send_request(OP_READ, m_last_ms + 32'd5, 1'b0, 1'b0, 1'b1);
        send_request(OP_READ, m_last_ms + 32'd4194304, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic random_request;
        logic        op_r;
        logic [31:0] delta;
        int          r;
        op_r = ($urandom_range(0, 3) == 0) ? OP_READ : OP_PULSE;
        r = $urandom_range(0, 99);
        if (r < 15)
            delta = $urandom_range(0, 32'(m_min_period));
        else if (r < 75)
            delta = 32'(m_min_period) + $urandom_range(0, 2000);
        else if (r < 90)
            delta = $urandom_range(0, 200000);
        else if (r < 95)
            delta = $urandom_range(4194300, 4194310);
        else
            delta = $urandom();
        send_request(op_r, m_last_ms + delta, $urandom_range(0, 7) == 0,
                     $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
    endtask

    task automatic test_random_phases;
        logic [15:0] circ_d;
        logic [15:0] minp_d;
        logic [15:0] mins_d;
        int          pause_at;
        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 0) begin
                configure({4'($urandom), CIRC_RST}, {6'($urandom), MIN_PER_RST},
                          MIN_SPD_RST, 16'h0000);
            end
            else if (phase == 1) begin
                configure(16'h0FA0, 16'h03E8, 16'd0, 16'h0001);
            end
            else if (phase == 2) begin
                configure(16'h0064, 16'h0000, 16'hFFFF, 16'h0001);
            end
            else begin
                circ_d = {4'($urandom), 12'($urandom_range(100, 4000))};
                minp_d = {6'($urandom), 10'($urandom_range(0, 1000))};
                mins_d = ($urandom_range(0, 4) == 0) ? 16'($urandom())
                                                      : 16'($urandom_range(0, 3000));
                configure(circ_d, minp_d, mins_d, 16'($urandom()));
            end
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            pause_at = $urandom_range(20, 90);
            for (int k = 0; k < 110; k++) begin
                if (k == pause_at)
                    hold_until_drained();
                if (k == 55) begin
                    sender_idle   = ~sender_idle;
                    receiver_idle = ($urandom_range(0, 1) != 0);
                end
                random_request();
            end
        end
    endtask

    initial begin
        rst_n             <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_index         <= CFG_CIRC;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        op                <= OP_PULSE;
        now_ms            <= '0;
        clear_moving_time <= 1'b0;
        clear_total_revs  <= 1'b0;
        clear_trip_revs   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_defaults();
        test_directed_extremes();
        test_random_phases();
        wait_idle();
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("testbench: done, clean");
        end
        else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/wspm_pkg.sv
sv/wspm_ctrl.sv
sv/wspm_dp.sv
sv/wheel_speed_period_meter_core.sv
bench/testbench.sv
